// ----- rtl/core/gguf_kv_pkg.sv -----
// ----------------------------------------------------------------------------
// gguf_kv_pkg
// Types, codes and helper functions for the model-file metadata parser.
// ----------------------------------------------------------------------------
package gguf_kv_pkg;

   localparam int unsigned HeaderBytes = 24;
   localparam int unsigned CountFirst  = 16;

   localparam logic [4:0] HeaderLast   = 5'(HeaderBytes - 1);
   localparam logic [4:0] CountLow     = 5'(CountFirst);
   localparam logic [4:0] CountHigh    = 5'(HeaderBytes);
   localparam logic [4:0] LenLast      = 5'd7;
   localparam logic [4:0] TypeLast     = 5'd3;

   localparam logic [7:0] CharLow      = 8'd32;
   localparam logic [7:0] CharHigh     = 8'd127;
   localparam logic [7:0] CharFill     = 8'h3F;

   localparam logic [31:0] TypeU8      = 32'd0;
   localparam logic [31:0] TypeI8      = 32'd1;
   localparam logic [31:0] TypeU16     = 32'd2;
   localparam logic [31:0] TypeI16     = 32'd3;
   localparam logic [31:0] TypeU32     = 32'd4;
   localparam logic [31:0] TypeI32     = 32'd5;
   localparam logic [31:0] TypeF32     = 32'd6;
   localparam logic [31:0] TypeBool    = 32'd7;
   localparam logic [31:0] TypeString  = 32'd8;
   localparam logic [31:0] TypeArray   = 32'd9;

   localparam logic [3:0] RoleHeader   = 4'd0;
   localparam logic [3:0] RoleKeyLen   = 4'd1;
   localparam logic [3:0] RoleKeyChar  = 4'd2;
   localparam logic [3:0] RoleType     = 4'd3;
   localparam logic [3:0] RoleValue    = 4'd4;
   localparam logic [3:0] RoleStrLen   = 4'd5;
   localparam logic [3:0] RoleStrChar  = 4'd6;
   localparam logic [3:0] RoleElemType = 4'd7;
   localparam logic [3:0] RoleCount    = 4'd8;
   localparam logic [3:0] RoleElement  = 4'd9;
   localparam logic [3:0] RoleTrail    = 4'd10;

   typedef enum logic [11:0] {
      PhHeader   = 12'b000000000001,
      PhKeyLen   = 12'b000000000010,
      PhKeyChar  = 12'b000000000100,
      PhType     = 12'b000000001000,
      PhValue    = 12'b000000010000,
      PhStrLen   = 12'b000000100000,
      PhStrChar  = 12'b000001000000,
      PhElemType = 12'b000010000000,
      PhCount    = 12'b000100000000,
      PhElemLen  = 12'b001000000000,
      PhTrail    = 12'b010000000000,
      PhElemBody = 12'b100000000000
   } phase_type;

   function automatic logic [63:0] size_of_type(input logic [31:0] t);
      logic [63:0] size;
      size = 64'd8;
      if (t inside {TypeU8, TypeI8, TypeBool}) begin
         size = 64'd1;
      end else if (t inside {TypeU16, TypeI16}) begin
         size = 64'd2;
      end else if (t inside {TypeU32, TypeI32, TypeF32}) begin
         size = 64'd4;
      end
      return size;
   endfunction

   function automatic logic [7:0] show_char(input logic [7:0] b);
      return (b >= CharLow && b < CharHigh) ? b : CharFill;
   endfunction

endpackage

// ----- rtl/core/gguf_metadata_kv_parser.sv -----
// Each accepted byte is held in the input register, and its result is then registered in the output register.
// One byte per cycle while rsp_stall is low, set by the single parser state update stage.
// While a result waits on rsp_stall the input register holds one more byte, then stalls.
// Reset is synchronous and clears both stages and the parser to the header phase.
// A byte flagged start_of_file restarts the parser as header byte zero.
// ----------------------------------------------------------------------------
// gguf_metadata_kv_parser
// Streaming parser that tags each metadata byte of a model file with its role.
// ----------------------------------------------------------------------------
module gguf_metadata_kv_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_start_of_file,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_byte_role,
   output logic [63:0]        rsp_entry_index,
   output logic [7:0]         rsp_shown_char,
   output logic [31:0]        rsp_value_type,
   output logic signed [32:0] rsp_scalar_value,
   output logic               rsp_scalar_done,
   output logic               rsp_entry_done,
   output logic               rsp_stream_finished
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   in_sof_ff;

   gguf_kv_pkg::phase_type phase_ff, phase_in;
   logic [4:0]             fpos_ff, fpos_in;
   logic [63:0]            asm_ff, asm_in;
   logic [63:0]            bytes_left_ff, bytes_left_in;
   logic [63:0]            array_left_ff, array_left_in;
   logic [31:0]            elem_type_ff, elem_type_in;
   logic [31:0]            entry_type_ff, entry_type_in;
   logic [63:0]            entries_left_ff, entries_left_in;
   logic [63:0]            entry_count_ff, entry_count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [3:0]             role_ff, role_in;
   logic [63:0]            index_ff, index_in;
   logic [7:0]             char_ff, char_in;
   logic [31:0]            vtype_ff, vtype_in;
   logic signed [32:0]     sval_ff, sval_in;
   logic                   sdone_ff, sdone_in;
   logic                   edone_ff, edone_in;
   logic                   finished_ff, finished_in;

   logic                   req_accept;
   logic                   advance;

   gguf_kv_pkg::phase_type ph;
   logic [4:0]             fp, fp_inc;
   logic [63:0]            asm_cur, asm_col;
   logic [63:0]            bl, al, el, ec;
   logic [31:0]            et_elem, et_entry;
   logic [63:0]            bl_dec, al_dec, el_dec;
   logic                   lane_hit;
   logic                   do_finish, do_begin, do_end;

   assign req_stall  = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_comb begin
      ph       = in_sof_ff ? gguf_kv_pkg::PhHeader : phase_ff;
      fp       = in_sof_ff ? 5'd0  : fpos_ff;
      asm_cur  = in_sof_ff ? 64'd0 : asm_ff;
      bl       = in_sof_ff ? 64'd0 : bytes_left_ff;
      al       = in_sof_ff ? 64'd0 : array_left_ff;
      et_elem  = in_sof_ff ? 32'd0 : elem_type_ff;
      et_entry = in_sof_ff ? 32'd0 : entry_type_ff;
      el       = in_sof_ff ? 64'd0 : entries_left_ff;
      ec       = in_sof_ff ? 64'd0 : entry_count_ff;

      fp_inc = fp + 5'd1;
      bl_dec = bl - 64'd1;
      al_dec = al - 64'd1;
      el_dec = el - 64'd1;

      if (ph == gguf_kv_pkg::PhHeader) begin
         lane_hit = (fp >= gguf_kv_pkg::CountLow) && (fp < gguf_kv_pkg::CountHigh);
      end else begin
         lane_hit = (fp[4:3] == 2'b00);
      end
      asm_col = asm_cur;
      for (int i = 0; i < 8; i++) begin
         if (lane_hit && (fp[2:0] == 3'(i))) begin
            asm_col[8*i +: 8] = asm_cur[8*i +: 8] | in_byte_ff;
         end
      end

      phase_in        = ph;
      fpos_in         = fp;
      asm_in          = asm_cur;
      bytes_left_in   = bl;
      array_left_in   = al;
      elem_type_in    = et_elem;
      entry_type_in   = et_entry;
      entries_left_in = el;
      entry_count_in  = ec;

      role_in  = gguf_kv_pkg::RoleTrail;
      index_in = ec;
      char_in  = 8'd0;
      sval_in  = '0;
      sdone_in = 1'b0;
      edone_in = 1'b0;
      do_finish = 1'b0;
      do_begin  = 1'b0;
      do_end    = 1'b0;

      case (ph)
         gguf_kv_pkg::PhHeader: begin
            role_in = gguf_kv_pkg::RoleHeader;
            asm_in  = asm_col;
            fpos_in = fp_inc;
            if (fp == gguf_kv_pkg::HeaderLast) begin
               entries_left_in = asm_col;
               fpos_in  = 5'd0;
               asm_in   = 64'd0;
               phase_in = (asm_col == 64'd0) ? gguf_kv_pkg::PhTrail : gguf_kv_pkg::PhKeyLen;
            end
         end
         gguf_kv_pkg::PhKeyLen: begin
            role_in = gguf_kv_pkg::RoleKeyLen;
            if (fp == 5'd0) begin
               entry_type_in = 32'd0;
            end
            asm_in  = asm_col;
            fpos_in = fp_inc;
            if (fp == gguf_kv_pkg::LenLast) begin
               bytes_left_in = asm_col;
               fpos_in  = 5'd0;
               asm_in   = 64'd0;
               phase_in = (asm_col != 64'd0) ? gguf_kv_pkg::PhKeyChar : gguf_kv_pkg::PhType;
            end
         end
         gguf_kv_pkg::PhKeyChar: begin
            role_in       = gguf_kv_pkg::RoleKeyChar;
            char_in       = gguf_kv_pkg::show_char(in_byte_ff);
            bytes_left_in = bl_dec;
            if (bl_dec == 64'd0) begin
               phase_in = gguf_kv_pkg::PhType;
            end
         end
         gguf_kv_pkg::PhType: begin
            role_in = gguf_kv_pkg::RoleType;
            asm_in  = asm_col;
            fpos_in = fp_inc;
            if (fp == gguf_kv_pkg::TypeLast) begin
               entry_type_in = asm_col[31:0];
               fpos_in = 5'd0;
               asm_in  = 64'd0;
               if (asm_col[31:0] == gguf_kv_pkg::TypeString) begin
                  phase_in = gguf_kv_pkg::PhStrLen;
               end else if (asm_col[31:0] == gguf_kv_pkg::TypeArray) begin
                  phase_in = gguf_kv_pkg::PhElemType;
               end else begin
                  bytes_left_in = gguf_kv_pkg::size_of_type(asm_col[31:0]);
                  phase_in      = gguf_kv_pkg::PhValue;
               end
            end
         end
         gguf_kv_pkg::PhValue: begin
            role_in       = gguf_kv_pkg::RoleValue;
            asm_in        = asm_col;
            fpos_in       = fp_inc;
            bytes_left_in = bl_dec;
            if (bl_dec == 64'd0) begin
               if (et_entry <= gguf_kv_pkg::TypeBool) begin
                  sdone_in = 1'b1;
                  if (et_entry inside {gguf_kv_pkg::TypeU8, gguf_kv_pkg::TypeI8,
                                       gguf_kv_pkg::TypeBool}) begin
                     sval_in = {{25{asm_col[7]}}, asm_col[7:0]};
                  end else if (et_entry inside {gguf_kv_pkg::TypeU16,
                                                gguf_kv_pkg::TypeI16}) begin
                     sval_in = {17'd0, asm_col[15:0]};
                  end else begin
                     sval_in = {1'b0, asm_col[31:0]};
                  end
               end
               do_end = 1'b1;
            end
         end
         gguf_kv_pkg::PhStrLen: begin
            role_in = gguf_kv_pkg::RoleStrLen;
            asm_in  = asm_col;
            fpos_in = fp_inc;
            if (fp == gguf_kv_pkg::LenLast) begin
               bytes_left_in = asm_col;
               fpos_in = 5'd0;
               asm_in  = 64'd0;
               if (asm_col == 64'd0) begin
                  do_end = 1'b1;
               end else begin
                  phase_in = gguf_kv_pkg::PhStrChar;
               end
            end
         end
         gguf_kv_pkg::PhStrChar: begin
            role_in       = gguf_kv_pkg::RoleStrChar;
            char_in       = gguf_kv_pkg::show_char(in_byte_ff);
            bytes_left_in = bl_dec;
            if (bl_dec == 64'd0) begin
               do_end = 1'b1;
            end
         end
         gguf_kv_pkg::PhElemType: begin
            role_in = gguf_kv_pkg::RoleElemType;
            asm_in  = asm_col;
            fpos_in = fp_inc;
            if (fp == gguf_kv_pkg::TypeLast) begin
               elem_type_in = asm_col[31:0];
               fpos_in  = 5'd0;
               asm_in   = 64'd0;
               phase_in = gguf_kv_pkg::PhCount;
            end
         end
         gguf_kv_pkg::PhCount: begin
            role_in = gguf_kv_pkg::RoleCount;
            asm_in  = asm_col;
            fpos_in = fp_inc;
            if (fp == gguf_kv_pkg::LenLast) begin
               array_left_in = asm_col;
               fpos_in = 5'd0;
               asm_in  = 64'd0;
               if (asm_col == 64'd0) begin
                  do_end = 1'b1;
               end else begin
                  do_begin = 1'b1;
               end
            end
         end
         gguf_kv_pkg::PhElemLen: begin
            role_in = gguf_kv_pkg::RoleElement;
            asm_in  = asm_col;
            fpos_in = fp_inc;
            if (fp == gguf_kv_pkg::LenLast) begin
               bytes_left_in = asm_col;
               fpos_in = 5'd0;
               asm_in  = 64'd0;
               if (asm_col == 64'd0) begin
                  do_finish = 1'b1;
               end else begin
                  phase_in = gguf_kv_pkg::PhElemBody;
               end
            end
         end
         gguf_kv_pkg::PhElemBody: begin
            role_in       = gguf_kv_pkg::RoleElement;
            bytes_left_in = bl_dec;
            if (bl_dec == 64'd0) begin
               do_finish = 1'b1;
            end
         end
         default: begin
            role_in  = gguf_kv_pkg::RoleTrail;
            phase_in = gguf_kv_pkg::PhTrail;
         end
      endcase

      if (do_finish) begin
         array_left_in = al_dec;
         if (al_dec == 64'd0) begin
            do_end = 1'b1;
         end else begin
            do_begin = 1'b1;
         end
      end

      if (do_begin) begin
         fpos_in = 5'd0;
         asm_in  = 64'd0;
         if (et_elem == gguf_kv_pkg::TypeString) begin
            phase_in = gguf_kv_pkg::PhElemLen;
         end else begin
            bytes_left_in = gguf_kv_pkg::size_of_type(et_elem);
            phase_in      = gguf_kv_pkg::PhElemBody;
         end
      end

      if (do_end) begin
         edone_in        = 1'b1;
         entry_count_in  = ec + 64'd1;
         entries_left_in = el_dec;
         fpos_in         = 5'd0;
         asm_in          = 64'd0;
         phase_in = (el_dec == 64'd0) ? gguf_kv_pkg::PhTrail : gguf_kv_pkg::PhKeyLen;
      end

      vtype_in    = (role_in inside {[gguf_kv_pkg::RoleType:gguf_kv_pkg::RoleElement]})
                    ? entry_type_in : 32'd0;
      finished_in = (phase_in == gguf_kv_pkg::PhTrail);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         phase_ff        <= gguf_kv_pkg::PhHeader;
         fpos_ff         <= 5'd0;
         asm_ff          <= 64'd0;
         bytes_left_ff   <= 64'd0;
         array_left_ff   <= 64'd0;
         elem_type_ff    <= 32'd0;
         entry_type_ff   <= 32'd0;
         entries_left_ff <= 64'd0;
         entry_count_ff  <= 64'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff        <= phase_in;
            fpos_ff         <= fpos_in;
            asm_ff          <= asm_in;
            bytes_left_ff   <= bytes_left_in;
            array_left_ff   <= array_left_in;
            elem_type_ff    <= elem_type_in;
            entry_type_ff   <= entry_type_in;
            entries_left_ff <= entries_left_in;
            entry_count_ff  <= entry_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_data_byte;
         in_sof_ff  <= req_start_of_file;
      end
      if (advance) begin
         role_ff     <= role_in;
         index_ff    <= index_in;
         char_ff     <= char_in;
         vtype_ff    <= vtype_in;
         sval_ff     <= sval_in;
         sdone_ff    <= sdone_in;
         edone_ff    <= edone_in;
         finished_ff <= finished_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_byte_role       = role_ff;
   assign rsp_entry_index     = index_ff;
   assign rsp_shown_char      = char_ff;
   assign rsp_value_type      = vtype_ff;
   assign rsp_scalar_value    = sval_ff;
   assign rsp_scalar_done     = sdone_ff;
   assign rsp_entry_done      = edone_ff;
   assign rsp_stream_finished = finished_ff;

   a_scalar_on_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scalar_done |->
         rsp_byte_role == gguf_kv_pkg::RoleValue && rsp_value_type <= gguf_kv_pkg::TypeBool)
      else $error("scalar_done outside a scalar value byte");

   a_char_on_text: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_shown_char != 8'd0 |->
         rsp_byte_role == gguf_kv_pkg::RoleKeyChar || rsp_byte_role == gguf_kv_pkg::RoleStrChar)
      else $error("shown_char set on a byte that is not text");

   a_entry_done_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_done |->
         rsp_byte_role != gguf_kv_pkg::RoleHeader && rsp_byte_role != gguf_kv_pkg::RoleTrail &&
         rsp_stream_finished == (phase_ff == gguf_kv_pkg::PhTrail))
      else $error("entry_done on a header or trailing byte");

   a_trail_finished: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_role == gguf_kv_pkg::RoleTrail |-> rsp_stream_finished)
      else $error("trailing byte while the stream is not finished");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && !advance)
      else $error("input stalled while a stage is free");

endmodule

// ----- test/tb_gguf_metadata_kv_parser.sv -----
// ----------------------------------------------------------------------------
// tb_gguf_metadata_kv_parser
// Streams model-file byte sequences into the metadata parser and checks every
// tagged byte against a cycle-free parser model kept inside this bench.
// Directed files cover the header, every value type, empty keys, strings and
// arrays, runaway lengths and restarts; random files, broken files and noise
// follow under changing sender and receiver stall rates.
// ----------------------------------------------------------------------------
module tb_gguf_metadata_kv_parser;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] UnknownType = 32'd10;
   localparam logic [31:0] OddType     = 32'h8000_0000;
   localparam logic [31:0] TopType     = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [3:0]         role;
      logic [63:0]        index;
      logic [7:0]         shown;
      logic [31:0]        vtype;
      logic signed [32:0] scalar;
      logic               scalar_done;
      logic               entry_done;
      logic               finished;
   } byte_tag_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_data_byte = 8'd0;
   logic               req_start_of_file = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [3:0]         rsp_byte_role;
   logic [63:0]        rsp_entry_index;
   logic [7:0]         rsp_shown_char;
   logic [31:0]        rsp_value_type;
   logic signed [32:0] rsp_scalar_value;
   logic               rsp_scalar_done;
   logic               rsp_entry_done;
   logic               rsp_stream_finished;

   byte_tag_type expected_tags[$];
   logic [7:0]   file_bytes[$];
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_idle_pct = 0;
   int unsigned  hold_request = 0;
   int unsigned  hold_left = 0;
   int unsigned  bytes_sent = 0;
   int unsigned  tags_seen = 0;
   int unsigned  error_count = 0;

   gguf_kv_pkg::phase_type parse_phase;
   logic [4:0]  field_pos;
   logic [63:0] field_acc;
   logic [63:0] run_left;
   logic [63:0] elems_left;
   logic [31:0] elem_type;
   logic [31:0] cur_type;
   logic [63:0] entries_left;
   logic [63:0] entry_count;
   logic        entry_ended;

   gguf_metadata_kv_parser dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_start_of_file   (req_start_of_file),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_byte_role       (rsp_byte_role),
      .rsp_entry_index     (rsp_entry_index),
      .rsp_shown_char      (rsp_shown_char),
      .rsp_value_type      (rsp_value_type),
      .rsp_scalar_value    (rsp_scalar_value),
      .rsp_scalar_done     (rsp_scalar_done),
      .rsp_entry_done      (rsp_entry_done),
      .rsp_stream_finished (rsp_stream_finished)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic bit chance(int unsigned pct);
      return $urandom_range(99) < pct;
   endfunction

   function automatic int unsigned value_bytes(logic [31:0] t);
      case (t)
         gguf_kv_pkg::TypeU8, gguf_kv_pkg::TypeI8, gguf_kv_pkg::TypeBool:     return 1;
         gguf_kv_pkg::TypeU16, gguf_kv_pkg::TypeI16:                          return 2;
         gguf_kv_pkg::TypeU32, gguf_kv_pkg::TypeI32, gguf_kv_pkg::TypeF32:    return 4;
         default:                                                             return 8;
      endcase
   endfunction

   function automatic void clear_field();
      field_pos = '0;
      field_acc = '0;
   endfunction

   function automatic void parser_reset();
      parse_phase = gguf_kv_pkg::PhHeader;
      clear_field();
      run_left = '0;
      elems_left = '0;
      elem_type = '0;
      cur_type = '0;
      entries_left = '0;
      entry_count = '0;
      entry_ended = 1'b0;
   endfunction

   function automatic bit collect(logic [7:0] b, int unsigned width);
      if (field_pos < 5'd8) begin
         field_acc |= 64'(b) << (8 * field_pos);
      end
      field_pos = field_pos + 5'd1;
      return field_pos >= width;
   endfunction

   function automatic void start_entry();
      parse_phase = gguf_kv_pkg::PhKeyLen;
      clear_field();
   endfunction

   function automatic void end_entry();
      entry_ended = 1'b1;
      entry_count++;
      entries_left--;
      if (entries_left == 0) begin
         parse_phase = gguf_kv_pkg::PhTrail;
      end else begin
         start_entry();
      end
   endfunction

   function automatic void begin_element();
      clear_field();
      if (elem_type == gguf_kv_pkg::TypeString) begin
         parse_phase = gguf_kv_pkg::PhElemLen;
      end else begin
         run_left = 64'(value_bytes(elem_type));
         parse_phase = gguf_kv_pkg::PhElemBody;
      end
   endfunction

   function automatic void finish_element();
      elems_left--;
      if (elems_left == 0) begin
         end_entry();
      end else begin
         begin_element();
      end
   endfunction

   function automatic byte_tag_type parse_byte(logic [7:0] b, logic sof);
      byte_tag_type t;
      t = '0;
      if (sof) begin
         parser_reset();
      end
      entry_ended = 1'b0;
      t.index = entry_count;
      case (parse_phase)
         gguf_kv_pkg::PhHeader: begin
            t.role = gguf_kv_pkg::RoleHeader;
            if (field_pos >= gguf_kv_pkg::CountLow && field_pos < gguf_kv_pkg::CountHigh) begin
               field_acc |= 64'(b) << (8 * (field_pos - gguf_kv_pkg::CountLow));
            end
            field_pos = field_pos + 5'd1;
            if (field_pos >= gguf_kv_pkg::CountHigh) begin
               entries_left = field_acc;
               clear_field();
               if (entries_left == 0) begin
                  parse_phase = gguf_kv_pkg::PhTrail;
               end else begin
                  start_entry();
               end
            end
         end
         gguf_kv_pkg::PhKeyLen: begin
            t.role = gguf_kv_pkg::RoleKeyLen;
            if (field_pos == 0) begin
               cur_type = '0;
            end
            if (collect(b, 8)) begin
               run_left = field_acc;
               clear_field();
               parse_phase = (run_left != 0) ? gguf_kv_pkg::PhKeyChar : gguf_kv_pkg::PhType;
            end
         end
         gguf_kv_pkg::PhKeyChar: begin
            t.role = gguf_kv_pkg::RoleKeyChar;
            t.shown = (b >= gguf_kv_pkg::CharLow && b < gguf_kv_pkg::CharHigh)
                      ? b : gguf_kv_pkg::CharFill;
            run_left--;
            if (run_left == 0) begin
               parse_phase = gguf_kv_pkg::PhType;
            end
         end
         gguf_kv_pkg::PhType: begin
            t.role = gguf_kv_pkg::RoleType;
            if (collect(b, 4)) begin
               cur_type = field_acc[31:0];
               clear_field();
               if (cur_type == gguf_kv_pkg::TypeString) begin
                  parse_phase = gguf_kv_pkg::PhStrLen;
               end else if (cur_type == gguf_kv_pkg::TypeArray) begin
                  parse_phase = gguf_kv_pkg::PhElemType;
               end else begin
                  run_left = 64'(value_bytes(cur_type));
                  parse_phase = gguf_kv_pkg::PhValue;
               end
            end
         end
         gguf_kv_pkg::PhValue: begin
            t.role = gguf_kv_pkg::RoleValue;
            void'(collect(b, 8));
            run_left--;
            if (run_left == 0) begin
               if (cur_type <= gguf_kv_pkg::TypeBool) begin
                  t.scalar_done = 1'b1;
                  if (cur_type inside {gguf_kv_pkg::TypeU8, gguf_kv_pkg::TypeI8,
                                       gguf_kv_pkg::TypeBool}) begin
                     t.scalar = {{25{field_acc[7]}}, field_acc[7:0]};
                  end else if (cur_type inside {gguf_kv_pkg::TypeU16,
                                                gguf_kv_pkg::TypeI16}) begin
                     t.scalar = {17'd0, field_acc[15:0]};
                  end else begin
                     t.scalar = {1'b0, field_acc[31:0]};
                  end
               end
               clear_field();
               end_entry();
            end
         end
         gguf_kv_pkg::PhStrLen: begin
            t.role = gguf_kv_pkg::RoleStrLen;
            if (collect(b, 8)) begin
               run_left = field_acc;
               clear_field();
               if (run_left == 0) begin
                  end_entry();
               end else begin
                  parse_phase = gguf_kv_pkg::PhStrChar;
               end
            end
         end
         gguf_kv_pkg::PhStrChar: begin
            t.role = gguf_kv_pkg::RoleStrChar;
            t.shown = (b >= gguf_kv_pkg::CharLow && b < gguf_kv_pkg::CharHigh)
                      ? b : gguf_kv_pkg::CharFill;
            run_left--;
            if (run_left == 0) begin
               end_entry();
            end
         end
         gguf_kv_pkg::PhElemType: begin
            t.role = gguf_kv_pkg::RoleElemType;
            if (collect(b, 4)) begin
               elem_type = field_acc[31:0];
               clear_field();
               parse_phase = gguf_kv_pkg::PhCount;
            end
         end
         gguf_kv_pkg::PhCount: begin
            t.role = gguf_kv_pkg::RoleCount;
            if (collect(b, 8)) begin
               elems_left = field_acc;
               clear_field();
               if (elems_left == 0) begin
                  end_entry();
               end else begin
                  begin_element();
               end
            end
         end
         gguf_kv_pkg::PhElemLen: begin
            t.role = gguf_kv_pkg::RoleElement;
            if (collect(b, 8)) begin
               run_left = field_acc;
               clear_field();
               if (run_left == 0) begin
                  finish_element();
               end else begin
                  parse_phase = gguf_kv_pkg::PhElemBody;
               end
            end
         end
         gguf_kv_pkg::PhElemBody: begin
            t.role = gguf_kv_pkg::RoleElement;
            run_left--;
            if (run_left == 0) begin
               finish_element();
            end
         end
         default: begin
            t.role = gguf_kv_pkg::RoleTrail;
            parse_phase = gguf_kv_pkg::PhTrail;
         end
      endcase
      t.vtype = (t.role >= gguf_kv_pkg::RoleType && t.role <= gguf_kv_pkg::RoleElement)
                ? cur_type : '0;
      t.entry_done = entry_ended;
      t.finished = (parse_phase == gguf_kv_pkg::PhTrail);
      return t;
   endfunction

   task automatic report_error(string msg);
      error_count++;
      if (error_count <= 40) begin
         $display("ERROR at %0t ns: %s", $time, msg);
      end
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
         report_error($sformatf("%s of byte tag %0d: got %0h, expected %0h",
                                name, tags_seen, got, want));
      end
   endtask

   task automatic check_result();
      byte_tag_type want;
      if (expected_tags.size() == 0) begin
         report_error("byte tag arrived with no byte outstanding");
         return;
      end
      want = expected_tags.pop_front();
      check_field("byte_role", 64'(rsp_byte_role), 64'(want.role));
      check_field("entry_index", rsp_entry_index, want.index);
      check_field("shown_char", 64'(rsp_shown_char), 64'(want.shown));
      check_field("value_type", 64'(rsp_value_type), 64'(want.vtype));
      check_field("scalar_value", 64'(rsp_scalar_value), 64'(want.scalar));
      check_field("scalar_done", 64'(rsp_scalar_done), 64'(want.scalar_done));
      check_field("entry_done", 64'(rsp_entry_done), 64'(want.entry_done));
      check_field("stream_finished", 64'(rsp_stream_finished), 64'(want.finished));
      tags_seen++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         check_result();
      end
   end

   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= chance(recv_idle_pct);
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic sof);
      while (chance(send_idle_pct)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_start_of_file <= sof;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_tags.push_back(parse_byte(data, sof));
      bytes_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_tags.size() != 0);
   endtask

   task automatic send_bytes(int unsigned from, int unsigned upto);
      for (int unsigned i = from; i < upto; i++) begin
         send_byte(file_bytes[i], i == 0);
      end
   endtask

   task automatic send_file();
      send_bytes(0, file_bytes.size());
      file_bytes.delete();
   endtask

   function automatic void push_le(logic [63:0] v, int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         file_bytes.push_back(v[8*i +: 8]);
      end
   endfunction

   function automatic void push_random_bytes(int unsigned count);
      repeat (count) file_bytes.push_back(8'($urandom));
   endfunction

   function automatic void push_text(string s);
      push_le(64'(s.len()), 8);
      for (int i = 0; i < s.len(); i++) begin
         file_bytes.push_back(s[i]);
      end
   endfunction

   function automatic void push_random_text(int unsigned longest);
      int unsigned n;
      n = $urandom_range(0, longest);
      push_le(64'(n), 8);
      push_random_bytes(n);
   endfunction

   function automatic void start_header(logic [63:0] count);
      file_bytes.delete();
      push_random_bytes(16);
      push_le(count, 8);
   endfunction

   function automatic void add_scalar(string key, logic [31:0] t, logic [63:0] v);
      push_text(key);
      push_le(64'(t), 4);
      push_le(v, value_bytes(t));
   endfunction

   function automatic void add_string(string key, string val);
      push_text(key);
      push_le(64'(gguf_kv_pkg::TypeString), 4);
      push_text(val);
   endfunction

   function automatic void add_array_head(string key, logic [31:0] et, logic [63:0] count);
      push_text(key);
      push_le(64'(gguf_kv_pkg::TypeArray), 4);
      push_le(64'(et), 4);
      push_le(count, 8);
   endfunction

   function automatic logic [31:0] random_type();
      int unsigned sel;
      sel = $urandom_range(0, 13);
      if (sel <= 9) return sel;
      if (sel == 10) return gguf_kv_pkg::TypeString;
      if (sel == 11) return gguf_kv_pkg::TypeArray;
      if (sel == 12) return $urandom_range(UnknownType, 64);
      return $urandom;
   endfunction

   function automatic void add_random_entry();
      logic [31:0] kind;
      logic [31:0] et;
      int unsigned n;
      if (chance(3)) begin
         push_le({$urandom, $urandom}, 8);
      end else begin
         n = chance(10) ? 0 : $urandom_range(1, 6);
         push_le(64'(n), 8);
         push_random_bytes(n);
      end
      kind = random_type();
      push_le(64'(kind), 4);
      if (kind == gguf_kv_pkg::TypeString) begin
         push_random_text(6);
      end else if (kind == gguf_kv_pkg::TypeArray) begin
         et = random_type();
         n = $urandom_range(0, 4);
         push_le(64'(et), 4);
         push_le(64'(n), 8);
         repeat (n) begin
            if (et == gguf_kv_pkg::TypeString) begin
               push_random_text(3);
            end else begin
               push_random_bytes(value_bytes(et));
            end
         end
      end else begin
         push_random_bytes(value_bytes(kind));
      end
   endfunction

   function automatic void build_random_file(int unsigned n_entries);
      start_header(chance(5) ? {$urandom, $urandom} : 64'(n_entries));
      repeat (n_entries) add_random_entry();
      if (chance(25)) begin
         push_random_bytes($urandom_range(1, 4));
      end
   endfunction

   task automatic test_empty_file();
      start_header(64'd0);
      push_le(64'h5A_FF_00, 3);
      send_file();
      wait_drained();
   endtask

   task automatic test_scalars();
      start_header(64'd10);
      add_scalar("", gguf_kv_pkg::TypeU8, 64'hFF);
      add_scalar("k\037 ~\177\200\377", gguf_kv_pkg::TypeI8, 64'h80);
      add_scalar("b", gguf_kv_pkg::TypeBool, 64'h7F);
      add_scalar("u16", gguf_kv_pkg::TypeU16, 64'hFFFF);
      add_scalar("i16", gguf_kv_pkg::TypeI16, 64'h8000);
      add_scalar("u32", gguf_kv_pkg::TypeU32, 64'hFFFF_FFFF);
      add_scalar("i32", gguf_kv_pkg::TypeI32, 64'h8000_0000);
      add_scalar("f32", gguf_kv_pkg::TypeF32, 64'h3F80_0000);
      add_scalar("u64", UnknownType, 64'hFFFF_FFFF_FFFF_FFFF);
      add_scalar("x", TopType, 64'd0);
      push_random_bytes(2);
      send_file();
      wait_drained();
   endtask

   task automatic test_strings_arrays();
      start_header(64'd7);
      add_string("s0", "");
      add_string("name", "hi\n~\177");
      add_array_head("a0", gguf_kv_pkg::TypeU32, 64'd0);
      add_array_head("tok", gguf_kv_pkg::TypeString, 64'd3);
      push_text("");
      push_text("ab");
      push_text("\377");
      add_array_head("u16", gguf_kv_pkg::TypeU16, 64'd2);
      push_le(64'h8000_FFFF, 4);
      add_array_head("nest", gguf_kv_pkg::TypeArray, 64'd2);
      push_random_bytes(16);
      add_array_head("odd", OddType, 64'd1);
      push_le(64'hFFFF_FFFF_FFFF_FFFF, 8);
      push_random_bytes(1);
      send_file();
      wait_drained();
   endtask

   task automatic test_restart();
      start_header(64'hFFFF_FFFF_FFFF_FFFF);
      push_text("k");
      push_le(64'(gguf_kv_pkg::TypeString), 4);
      push_le(64'hFFFF_FFFF_FFFF_FFFF, 8);
      push_random_bytes(4);
      send_file();
      start_header(64'd2);
      add_array_head("", gguf_kv_pkg::TypeU8, 64'hFFFF_FFFF_FFFF_FFFF);
      push_random_bytes(6);
      send_file();
      start_header(64'd1);
      push_le(64'h8000_0000_0000_0001, 8);
      push_random_bytes(3);
      send_file();
      start_header(64'd1);
      file_bytes = file_bytes[0:9];
      send_file();
      start_header(64'd1);
      add_scalar("r", gguf_kv_pkg::TypeU8, 64'h01);
      send_file();
      wait_drained();
   endtask

   task automatic test_drain_pause();
      int unsigned half;
      build_random_file(4);
      half = file_bytes.size() / 2;
      send_bytes(0, half);
      wait_drained();
      send_bytes(half, file_bytes.size());
      file_bytes.delete();
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 80;
      build_random_file(6);
      send_file();
      wait_drained();
      send_idle_pct = 24;
      hold_request = 300;
      build_random_file(6);
      send_file();
      wait_drained();
   endtask

   task automatic test_random_files(int unsigned send_pct, int unsigned recv_pct,
                                    int unsigned quota);
      int unsigned target;
      int unsigned cut;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      target = bytes_sent + quota;
      while (bytes_sent < target) begin
         if (chance(8)) begin
            file_bytes.delete();
            push_random_bytes($urandom_range(1, 12));
            foreach (file_bytes[i]) begin
               send_byte(file_bytes[i], chance(10));
            end
            file_bytes.delete();
         end else begin
            build_random_file($urandom_range(0, 6));
            if (chance(12)) begin
               cut = $urandom_range(1, file_bytes.size() - 1);
               file_bytes = file_bytes[0:cut-1];
            end
            send_file();
         end
      end
      wait_drained();
   endtask

   initial begin
      parser_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 24;
      recv_idle_pct = 80;
      test_empty_file();
      test_scalars();
      test_strings_arrays();
      test_restart();
      test_drain_pause();
      test_backpressure();
      test_random_files(24, 80, 210);
      test_random_files(80, 24, 210);
      test_random_files(0, 0, 210);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- gguf_metadata_kv_parser.f -----
rtl/core/gguf_kv_pkg.sv
rtl/core/gguf_metadata_kv_parser.sv
test/tb_gguf_metadata_kv_parser.sv
